>>> rtl/core/tlfd_pkg.sv
// Package with shared types, constants and state codes of the feedback dispatcher.
package tlfd_pkg;

   localparam int CORES      = 4;
   localparam int SLOTS      = 64;
   localparam int PID_W      = 6;
   localparam int CORE_W     = 2;
   localparam int CNT_W      = 7;
   localparam int LEVELS     = 3;

   localparam logic [7:0] QUANTUM0_RESET = 8'd8;
   localparam logic [7:0] QUANTUM1_RESET = 8'd16;

   localparam logic CSR_QUANTUM0 = 1'b0;
   localparam logic CSR_QUANTUM1 = 1'b1;

   localparam logic FUNC_READY = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic             func;
      logic [PID_W-1:0] pid;
      logic [3:0]       burst_done;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       core;
      logic             busy_res;
      logic [PID_W-1:0] running_pid;
      logic [1:0]       level;
      logic [7:0]       quantum_left;
      logic             released;
      logic             demoted;
      logic [31:0]      switch_count;
      logic             last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RELEASE,
      ST_ADMIT,
      ST_DISPATCH,
      ST_DISP_WAIT,
      ST_REPORT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_req;
      logic              mark_ready;
      logic              release_core;
      logic              admit_id;
      logic              clear_pending;
      logic              pop_start;
      logic              pop_finish;
      logic              count_down;
      logic [CORE_W-1:0] core_idx;
      logic [PID_W-1:0]  id_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic core_busy;
      logic any_queued;
   } status_type;

endpackage

>>> rtl/core/tlfd_ram.sv
// Generic single-port-write, registered-read RAM.
module tlfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tlfd_datapath.sv
// Datapath: queues, pending set, per-core state and result word formation.
module tlfd_datapath import tlfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_word_type req_word,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_data,
   output status_type   status,
   output rsp_word_type rsp_word
);

   logic [7:0] quantum0_ff, quantum1_ff;
   req_word_type req_ff;
   logic [SLOTS-1:0] pending_ff, pending_in;
   logic [PID_W-1:0] head_ff [LEVELS];
   logic [PID_W-1:0] tail_ff [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CORES-1:0] busy_ff;
   logic [PID_W-1:0] pid_ff [CORES];
   logic [1:0]       level_ff [CORES];
   logic [7:0]       quantum_ff [CORES];
   logic [CORES-1:0] rel_ff, dem_ff;
   logic [31:0]      total_ff;
   logic [1:0]       pop_lv_ff;

   logic [LEVELS-1:0] wr_en;
   logic [PID_W-1:0]  wr_data;
   logic [PID_W-1:0]  rd_data [LEVELS];
   logic [1:0]        push_lv;
   logic              push_en;
   logic [1:0]        pop_lv;
   logic [1:0]        cur_level;
   logic              cur_busy;
   logic              cur_expired;

   assign cur_busy    = busy_ff[cmd.core_idx];
   assign cur_level   = level_ff[cmd.core_idx];
   assign cur_expired = (cur_level != 2'd2) && (quantum_ff[cmd.core_idx] == 8'd0);

   // Choose which queue takes a push this cycle.
   always_comb begin
      push_en = 1'b0;
      push_lv = 2'd0;
      wr_data = cmd.id_idx;
      if (cmd.release_core && cur_busy && !req_ff.burst_done[cmd.core_idx] && cur_expired)
      begin
         push_en = 1'b1;
         push_lv = cur_level + 2'd1;
         wr_data = pid_ff[cmd.core_idx];
      end else if (cmd.admit_id && pending_ff[cmd.id_idx]) begin
         push_en = 1'b1;
      end
      for (int l = 0; l < LEVELS; l++) begin
         wr_en[l] = push_en && (push_lv == 2'(l)) && (count_ff[l] != CNT_W'(SLOTS));
      end
   end

   // Highest-priority non-empty queue.
   always_comb begin
      if (count_ff[0] != '0)      pop_lv = 2'd0;
      else if (count_ff[1] != '0) pop_lv = 2'd1;
      else                        pop_lv = 2'd2;
   end

   // Queue storage, one RAM per level.
   for (genvar g = 0; g < LEVELS; g++) begin : g_fifo
      tlfd_ram #(.WIDTH(PID_W), .DEPTH(SLOTS)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (tail_ff[g]),
         .wr_data (wr_data),
         .rd_addr (head_ff[g]),
         .rd_data (rd_data[g])
      );
   end

   // Pending set update.
   always_comb begin
      pending_in = pending_ff;
      if (cmd.clear_pending) pending_in = '0;
      if (cmd.mark_ready) pending_in[req_ff.pid] = 1'b1;
   end

   // Control state: configuration, pointers, core state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum0_ff <= QUANTUM0_RESET;
         quantum1_ff <= QUANTUM1_RESET;
         pending_ff  <= '0;
         busy_ff     <= '0;
         total_ff    <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         for (int c = 0; c < CORES; c++) begin
            pid_ff[c]     <= '0;
            level_ff[c]   <= '0;
            quantum_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_QUANTUM0) quantum0_ff <= csr_data;
            else                           quantum1_ff <= csr_data;
         end
         pending_ff <= pending_in;
         for (int l = 0; l < LEVELS; l++) begin
            if (wr_en[l]) begin
               tail_ff[l] <= tail_ff[l] + 1'b1;
            end
         end
         // Release or demote one core.
         if (cmd.release_core && cur_busy) begin
            if (req_ff.burst_done[cmd.core_idx] || cur_expired) begin
               busy_ff[cmd.core_idx]    <= 1'b0;
               pid_ff[cmd.core_idx]     <= '0;
               level_ff[cmd.core_idx]   <= '0;
               quantum_ff[cmd.core_idx] <= '0;
            end
            if (!req_ff.burst_done[cmd.core_idx] && cur_expired) begin
               total_ff <= total_ff + 32'd1;
            end
         end
         // Begin a pop: advance head; data appears next cycle.
         if (cmd.pop_start) begin
            head_ff[pop_lv]  <= head_ff[pop_lv] + 1'b1;
            count_ff[pop_lv] <= count_ff[pop_lv] - 1'b1;
         end
         for (int l = 0; l < LEVELS; l++) begin
            if (wr_en[l] && !(cmd.pop_start && pop_lv == 2'(l))) begin
               count_ff[l] <= count_ff[l] + 1'b1;
            end
         end
         if (cmd.pop_finish) begin
            busy_ff[cmd.core_idx]  <= 1'b1;
            pid_ff[cmd.core_idx]   <= rd_data[pop_lv_ff];
            level_ff[cmd.core_idx] <= pop_lv_ff;
            quantum_ff[cmd.core_idx] <= (pop_lv_ff == 2'd0) ? quantum0_ff :
                                        (pop_lv_ff == 2'd1) ? quantum1_ff : 8'd0;
         end
         if (cmd.count_down) begin
            for (int c = 0; c < CORES; c++) begin
               if (busy_ff[c] && level_ff[c] != 2'd2 && quantum_ff[c] != 8'd0) begin
                  quantum_ff[c] <= quantum_ff[c] - 8'd1;
               end
            end
         end
      end
   end

   // Payload registers: request word, pop level and event flags.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
         rel_ff <= '0;
         dem_ff <= '0;
      end
      if (cmd.pop_start) pop_lv_ff <= pop_lv;
      if (cmd.release_core && cur_busy) begin
         rel_ff[cmd.core_idx] <= req_ff.burst_done[cmd.core_idx];
         dem_ff[cmd.core_idx] <= !req_ff.burst_done[cmd.core_idx] && cur_expired;
      end
   end

   assign status.is_tick    = req_ff.func == FUNC_TICK;
   assign status.core_busy  = cur_busy;
   assign status.any_queued = (count_ff[0] != '0) || (count_ff[1] != '0) ||
                              (count_ff[2] != '0);

   // Result word for the core being reported.
   always_comb begin
      rsp_word.core         = cmd.core_idx;
      rsp_word.busy_res     = busy_ff[cmd.core_idx];
      rsp_word.running_pid  = pid_ff[cmd.core_idx];
      rsp_word.level        = level_ff[cmd.core_idx];
      rsp_word.quantum_left = quantum_ff[cmd.core_idx];
      rsp_word.released     = rel_ff[cmd.core_idx];
      rsp_word.demoted      = dem_ff[cmd.core_idx];
      rsp_word.switch_count = total_ff;
      rsp_word.last         = cmd.core_idx == CORE_W'(CORES - 1);
   end

   // A queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CNT_W'(SLOTS) && count_ff[1] <= CNT_W'(SLOTS) &&
      count_ff[2] <= CNT_W'(SLOTS))
      else $error("queue count beyond depth");

   // A demotion never leaves the switch total unchanged.
   a_demote_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.release_core && cur_busy && !req_ff.burst_done[cmd.core_idx] && cur_expired)
      |=> total_ff == $past(total_ff) + 32'd1)
      else $error("demotion not counted");

   // A level-2 process never holds a quantum.
   a_level2_quantum: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_finish && pop_lv_ff == 2'd2 |=> quantum_ff[$past(cmd.core_idx)] == 8'd0)
      else $error("level-2 process given a quantum");

endmodule

>>> rtl/core/tlfd_control.sv
// Controller: marks a ready word pending; sequences a tick word through release, admit, dispatch, countdown and report.
module tlfd_control import tlfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic [CORE_W-1:0] core_ff, core_in;
   logic [PID_W-1:0]  id_ff, id_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         core_ff  <= '0;
         id_ff    <= '0;
      end else begin
         state_ff <= state_in;
         core_ff  <= core_in;
         id_ff    <= id_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      core_in   = core_ff;
      id_in     = id_ff;
      cmd       = '0;
      cmd.core_idx = core_ff;
      cmd.id_idx   = id_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_RELEASE;
               core_in      = '0;
               id_in        = '0;
            end
         end
         ST_RELEASE: begin
            if (!status.is_tick) begin
               cmd.mark_ready = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.release_core = 1'b1;
               core_in = core_ff + 1'b1;
               if (core_ff == CORE_W'(CORES - 1)) begin
                  core_in  = '0;
                  state_in = ST_ADMIT;
               end
            end
         end
         ST_ADMIT: begin
            cmd.admit_id = 1'b1;
            id_in = id_ff + 1'b1;
            if (id_ff == PID_W'(SLOTS - 1)) begin
               cmd.clear_pending = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.core_busy && status.any_queued) begin
               cmd.pop_start = 1'b1;
               state_in = ST_DISP_WAIT;
            end else if (core_ff == CORE_W'(CORES - 1)) begin
               core_in  = '0;
               cmd.count_down = 1'b1;
               state_in = ST_REPORT;
            end else begin
               core_in = core_ff + 1'b1;
            end
         end
         ST_DISP_WAIT: begin
            cmd.pop_finish = 1'b1;
            state_in = ST_DISPATCH;
         end
         ST_REPORT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               core_in = core_ff + 1'b1;
               if (core_ff == CORE_W'(CORES - 1)) begin
                  core_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Input is only taken when idle.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE)
      else $error("input taken outside idle");

   // Results only in the report phase.
   a_rsp_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_REPORT)
      else $error("result outside report");

   // A pop is always completed on the following cycle.
   a_pop_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_start |=> cmd.pop_finish)
      else $error("pop not completed");

endmodule

>>> rtl/core/three_level_feedback_dispatcher.sv
// Top level of the three-level feedback queue dispatcher.
// A ready word marks its process pending. A tick word checks each core for release or
// demotion, scans all 64 process ids for admission (one process id a cycle), pops a
// queued process into each idle core, then gives four result words, one per core in core
// order, each held until taken. Queue RAMs hold undefined data after reset; only written
// entries are ever read. Quantum registers reset to 8 and 16; the user must write them
// through the csr port only while the block is idle, as the block does not enforce it.
module three_level_feedback_dispatcher import tlfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [7:0]   csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tlfd_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule
